[hdl/ptsu_pkg.sv]
// ----------------------------------------------------------------------------
// ptsu_pkg
// Shared types, codes and helpers of the parity-routed twin stack unit.
// ----------------------------------------------------------------------------
package ptsu_pkg;

	localparam int unsigned DEPTH_DEF      = 256;
	localparam int unsigned DATA_WIDTH_DEF = 32;
	localparam int unsigned CAP_W          = 9;
	localparam int unsigned FUNC_W         = 2;

	// function codes of a command transaction
	localparam logic [FUNC_W-1:0] FN_PUSH     = 2'd0;
	localparam logic [FUNC_W-1:0] FN_POP_ODD  = 2'd1;
	localparam logic [FUNC_W-1:0] FN_POP_EVEN = 2'd2;

	// reset value of the capacity register before clamping
	localparam logic [CAP_W-1:0] CAP_RAW_RESET = 9'd256;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_OVERFLOW = 2'd1,
		ST_EMPTY    = 2'd2
	} status_t;

	// memory request and outcome of one command
	typedef struct packed {
		logic    wr_en;
		logic    rd_en;
		status_t status;
	} op_t;

	// clamp a written capacity to 1..depth
	function automatic logic [CAP_W-1:0] clamp_cap(input logic [CAP_W-1:0] raw,
		input int unsigned depth);
		logic [CAP_W-1:0] c;
		c = raw;
		if (c == '0) begin
			c = CAP_W'(1);
		end
		if (32'(c) > depth) begin
			c = CAP_W'(depth);
		end
		return c;
	endfunction

endpackage

[hdl/ptsu_if.sv]
// ----------------------------------------------------------------------------
// ptsu_if
// Valid/ready channels of the twin stack unit: command and response.
// ----------------------------------------------------------------------------
interface ptsu_cmd_if #(
	parameter int unsigned DATA_WIDTH = 32
) ();
	logic                         valid;
	logic                         ready;
	logic [1:0]                   func;
	logic signed [DATA_WIDTH-1:0] value;

	modport source (output valid, output func, output value, input ready);
	modport sink   (input valid, input func, input value, output ready);
endinterface

interface ptsu_rsp_if #(
	parameter int unsigned DATA_WIDTH = 32
) ();
	logic                         valid;
	logic                         ready;
	logic signed [DATA_WIDTH-1:0] value_out;
	logic [1:0]                   status;

	modport source (output valid, output value_out, output status, input ready);
	modport sink   (input valid, input value_out, input status, output ready);
endinterface

[hdl/ptsu_mem.sv]
// ----------------------------------------------------------------------------
// ptsu_mem
// Single-port shared stack memory with a registered read port.
// ----------------------------------------------------------------------------
module ptsu_mem
	import ptsu_pkg::*;
#(
	parameter int unsigned DEPTH      = DEPTH_DEF,
	parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEF,
	localparam int unsigned AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                  clk,
	input  op_t                   op,
	input  logic [AW-1:0]         addr,
	input  logic [DATA_WIDTH-1:0] wdata,
	output logic [DATA_WIDTH-1:0] rdata
);

	logic [DATA_WIDTH-1:0] mem [DEPTH];
	logic [DATA_WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (op.wr_en) begin
			mem[addr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (op.rd_en) begin
			rdata_q <= mem[addr];
		end
	end

	assign rdata = rdata_q;

endmodule

[hdl/ptsu_ctrl.sv]
// ----------------------------------------------------------------------------
// ptsu_ctrl
// Stack occupancy counters, capacity register and address generation.
// ----------------------------------------------------------------------------
module ptsu_ctrl
	import ptsu_pkg::*;
#(
	parameter int unsigned DEPTH = DEPTH_DEF,
	localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [CAP_W-1:0] cfg_data,
	input  logic             acc,
	input  logic [FUNC_W-1:0] func,
	input  logic             odd_bit,
	output op_t              op,
	output logic [AW-1:0]    addr
);

	logic [CAP_W-1:0] cap_q;
	logic [CAP_W-1:0] ec_q, oc_q;   // entries held by even and odd stack
	logic [CAP_W-1:0] ec_d, oc_d;
	logic [CAP_W-1:0] addr9;
	logic [CAP_W:0]   used;
	logic             full;
	op_t              op_c;

	assign used = {1'b0, ec_q} + {1'b0, oc_q};
	assign full = (used == {1'b0, cap_q});

	always_comb begin
		op_c   = '{wr_en: 1'b0, rd_en: 1'b0, status: ST_OK};
		ec_d   = ec_q;
		oc_d   = oc_q;
		addr9  = '0;
		unique case (func)
			FN_PUSH: begin
				if (full) begin
					op_c.status = ST_OVERFLOW;
				end else if (odd_bit) begin
					op_c.wr_en = 1'b1;
					addr9      = cap_q - CAP_W'(1) - oc_q;
					oc_d       = oc_q + CAP_W'(1);
				end else begin
					op_c.wr_en = 1'b1;
					addr9      = ec_q;
					ec_d       = ec_q + CAP_W'(1);
				end
			end
			FN_POP_ODD: begin
				if (oc_q == '0) begin
					op_c.status = ST_EMPTY;
				end else begin
					op_c.rd_en = 1'b1;
					addr9      = cap_q - oc_q;
					oc_d       = oc_q - CAP_W'(1);
				end
			end
			FN_POP_EVEN: begin
				if (ec_q == '0) begin
					op_c.status = ST_EMPTY;
				end else begin
					op_c.rd_en = 1'b1;
					addr9      = ec_q - CAP_W'(1);
					ec_d       = ec_q - CAP_W'(1);
				end
			end
			default: begin
				// unused code: no change, plain ok
			end
		endcase
	end

	always_comb begin
		op        = op_c;
		op.wr_en  = op_c.wr_en & acc;
		op.rd_en  = op_c.rd_en & acc;
		addr      = AW'(addr9);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= clamp_cap(CAP_RAW_RESET, DEPTH);
			ec_q  <= '0;
			oc_q  <= '0;
		end else if (cfg_we) begin
			cap_q <= clamp_cap(cfg_data, DEPTH);
			ec_q  <= '0;
			oc_q  <= '0;
		end else if (acc) begin
			ec_q  <= ec_d;
			oc_q  <= oc_d;
		end
	end

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used <= {1'b0, cap_q})
		else $error("stack occupancy exceeds capacity");

	a_cap_range: assert property (@(posedge clk) disable iff (!arst_n)
		(cap_q != '0) && (32'(cap_q) <= DEPTH))
		else $error("capacity register out of range");

	a_one_access: assert property (@(posedge clk) disable iff (!arst_n)
		!(op.wr_en && op.rd_en))
		else $error("read and write issued together");

endmodule

[hdl/parity_routed_twin_stack_unit.sv]
// ----------------------------------------------------------------------------
// parity_routed_twin_stack_unit
// Two LIFO stacks in one shared memory, pushes routed by value parity.
//
//   channel  dir  handshake      payload
//   cmd      in   valid/ready    func[1:0], value[DATA_WIDTH-1:0]
//   rsp      out  valid/ready    value_out[DATA_WIDTH-1:0], status[1:0]
//   cfg      in   cfg_we         cfg_data[8:0] = capacity
//
// One transaction per cycle while responses drain; each response appears in the
// cycle after its command, set by the registered read port of the shared memory.
// The response register holds a stalled result; cmd.ready drops only while
// it is full and rsp.ready is low.
// Reset (arst_n, asynchronous) empties both stacks and sets capacity to
// DEPTH clamped at 256; no memory clearing pass is needed.
// ----------------------------------------------------------------------------
module parity_routed_twin_stack_unit
	import ptsu_pkg::*;
#(
	parameter int unsigned DEPTH      = DEPTH_DEF,
	parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEF,
	localparam int unsigned AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             arst_n,
	ptsu_cmd_if.sink         cmd,
	ptsu_rsp_if.source       rsp,
	input  logic             cfg_we,
	input  logic [CAP_W-1:0] cfg_data
);

	logic                  acc;
	op_t                   op;
	logic [AW-1:0]         addr;
	logic [DATA_WIDTH-1:0] rdata;

	// response stage
	logic    valid_s1;
	status_t status_s1;
	logic    pop_s1;

	// take a new command whenever the response slot is free or draining
	assign cmd.ready = !valid_s1 || rsp.ready;
	assign acc       = cmd.valid && cmd.ready;

	ptsu_ctrl #(
		.DEPTH (DEPTH)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data),
		.acc      (acc),
		.func     (cmd.func),
		.odd_bit  (cmd.value[0]),
		.op       (op),
		.addr     (addr)
	);

	// pointers move at the accepting edge, so the next command always sees
	// the previous write already in memory: no forwarding path required
	ptsu_mem #(
		.DEPTH      (DEPTH),
		.DATA_WIDTH (DATA_WIDTH)
	) u_mem (
		.clk   (clk),
		.op    (op),
		.addr  (addr),
		.wdata (cmd.value),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (acc) begin
			valid_s1 <= 1'b1;
		end else if (rsp.ready) begin
			valid_s1 <= 1'b0;
		end
	end

	// hold status with the read data; the memory output register only
	// changes on the next accepted read, so it stays put while stalled
	always_ff @(posedge clk) begin
		if (acc) begin
			status_s1 <= op.status;
			pop_s1    <= op.rd_en;
		end
	end

	assign rsp.valid     = valid_s1;
	assign rsp.status    = status_s1;
	assign rsp.value_out = pop_s1 ? rdata : '0;

	a_rsp_follows: assert property (@(posedge clk) disable iff (!arst_n)
		acc |=> rsp.valid)
		else $error("accepted command produced no response");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && (rsp.status != 2'(ST_OK))) |-> (rsp.value_out == '0))
		else $error("failed transaction carries data");

	a_fail_no_access: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && (op.status != ST_OK)) |-> !(op.wr_en || op.rd_en))
		else $error("memory touched on failed transaction");

endmodule

[dv/tb_parity_routed_twin_stack_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_parity_routed_twin_stack_unit
// Self-checking bench for the twin stack unit. A behavioural model of the
// two stacks follows each accepted command and queues the expected
// response. Every response is then compared with the oldest queued one.
// Stimulus runs in two parts. A directed part hits the value extremes,
// empty pops, overflow, the spare function code and out-of-range
// capacities. The random part then runs across a spread of capacity
// settings, with both channels idling and stalling in turn.
// ----------------------------------------------------------------------------
module tb_parity_routed_twin_stack_unit;
	import ptsu_pkg::*;

	// function code with no operation behind it
	localparam logic [FUNC_W-1:0] FN_SPARE = 2'd3;

	localparam int SEGMENTS    = 13;
	localparam int SEG_ITEMS   = 100;
	localparam int WATCHDOG_NS = 3_200_000;

	typedef struct packed {
		logic [DATA_WIDTH_DEF-1:0] value_out;
		status_t                   status;
	} stack_rsp_t;

	// Twin stack model plus the queue of responses still owed by the block.
	class twin_stack_scoreboard;
		logic [DATA_WIDTH_DEF-1:0] mem [DEPTH_DEF];
		int                        cap;
		int                        even_top;
		int                        odd_top;
		stack_rsp_t                owed [$];
		int                        errors;
		int                        n_checked;
		int                        n_stored;
		int                        n_overflow;
		int                        n_popped;
		int                        n_empty;
		int                        n_spare;

		function new();
			cap      = int'(DEPTH_DEF);
			even_top = 0;
			odd_top  = cap - 1;
			foreach (mem[i]) mem[i] = '0;
		endfunction

		// capacity 0 behaves as 1; anything above the memory size as the full memory
		function void set_capacity(input logic [CAP_W-1:0] raw);
			if (raw == '0) begin
				cap = 1;
			end else if (int'(raw) > int'(DEPTH_DEF)) begin
				cap = int'(DEPTH_DEF);
			end else begin
				cap = int'(raw);
			end
			even_top = 0;
			odd_top  = cap - 1;
		endfunction

		function void note_command(input logic [FUNC_W-1:0] fn,
			input logic [DATA_WIDTH_DEF-1:0] val);
			stack_rsp_t e;
			e.value_out = '0;
			e.status    = ST_OK;
			case (fn)
				FN_PUSH: begin
					if (even_top > odd_top) begin
						e.status = ST_OVERFLOW;
						n_overflow++;
					end else if (val[0]) begin
						mem[odd_top] = val;
						odd_top--;
						n_stored++;
					end else begin
						mem[even_top] = val;
						even_top++;
						n_stored++;
					end
				end
				FN_POP_ODD: begin
					if (odd_top >= cap - 1) begin
						e.status = ST_EMPTY;
						n_empty++;
					end else begin
						odd_top++;
						e.value_out = mem[odd_top];
						n_popped++;
					end
				end
				FN_POP_EVEN: begin
					if (even_top <= 0) begin
						e.status = ST_EMPTY;
						n_empty++;
					end else begin
						even_top--;
						e.value_out = mem[even_top];
						n_popped++;
					end
				end
				default: begin
					n_spare++;
				end
			endcase
			owed.push_back(e);
		endfunction

		task report(input string msg);
			$display("[%0t] mismatch: %s", $time, msg);
			errors++;
		endtask

		task check_result(input logic [DATA_WIDTH_DEF-1:0] got_val,
			input logic [1:0] got_st);
			stack_rsp_t e;
			if (owed.size() == 0) begin
				report("response arrived with no command outstanding");
				return;
			end
			e = owed.pop_front();
			n_checked++;
			if (got_val !== e.value_out) begin
				report($sformatf("value_out %h, expected %h", got_val, e.value_out));
			end
			if (got_st !== e.status) begin
				report($sformatf("status %0d, expected %0d", got_st, e.status));
			end
		endtask

		function int pending();
			return owed.size();
		endfunction
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CAP_W-1:0]     cfg_data;
	int                   send_idle_pct;
	int                   recv_stall_pct;
	int                   cfg_writes;
	twin_stack_scoreboard sb = new();

	ptsu_cmd_if #(.DATA_WIDTH(DATA_WIDTH_DEF)) cmd_ch ();
	ptsu_rsp_if #(.DATA_WIDTH(DATA_WIDTH_DEF)) rsp_ch ();

	parity_routed_twin_stack_unit #(
		.DEPTH      (DEPTH_DEF),
		.DATA_WIDTH (DATA_WIDTH_DEF)
	) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd_ch),
		.rsp      (rsp_ch),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Response side: check on the pre-edge view of the handshake, then pick the
	// ready level for the next cycle. Stall at the rate the current phase sets.
	always @(posedge clk) begin
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			sb.check_result(rsp_ch.value_out, rsp_ch.status);
		end
		rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// Present one command, idling beforehand at the sender's rate, and hold it
	// until the block takes it. Log the transaction in the model at that edge.
	task automatic send_command(input logic [FUNC_W-1:0] fn,
		input logic [DATA_WIDTH_DEF-1:0] val);
		while ($urandom_range(99) < send_idle_pct) begin
			cmd_ch.valid <= 1'b0;
			@(posedge clk);
		end
		cmd_ch.valid <= 1'b1;
		cmd_ch.func  <= fn;
		cmd_ch.value <= val;
		do @(posedge clk); while (!cmd_ch.ready);
		sb.note_command(fn, val);
	endtask

	// Drop valid and hold off until every owed response has been taken, then
	// let the registered read pipe settle.
	task automatic wait_until_idle();
		cmd_ch.valid <= 1'b0;
		do @(posedge clk); while (sb.pending() != 0);
		repeat (2) @(posedge clk);
	endtask

	// Single-cycle register write; the model empties both stacks at that edge.
	task automatic write_capacity(input logic [CAP_W-1:0] raw);
		cfg_we   <= 1'b1;
		cfg_data <= raw;
		@(posedge clk);
		sb.set_capacity(raw);
		cfg_we <= 1'b0;
		cfg_writes++;
	endtask

	// Watchdog: end the run if the block stops answering.
	initial begin
		#WATCHDOG_NS;
		$display("[%0t] watchdog expired, %0d responses still owed", $time, sb.pending());
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		logic [CAP_W-1:0]          cap_plan [SEGMENTS];
		logic [FUNC_W-1:0]         fn;
		logic [DATA_WIDTH_DEF-1:0] val;
		int                        roll;
		int                        push_pct;

		// Mostly small capacities so that overflow comes round often; the
		// zero, all-ones and above-depth codes exercise the clamping.
		cap_plan = '{9'd3, 9'd1, 9'd256, 9'd8, 9'd511, 9'd17, 9'd4,
			9'd300, 9'd2, 9'd64, 9'd5, 9'd0, 9'd12};

		// Initialise the command side before the first edge; the response
		// side takes its ready level from the first edge on.
		arst_n         <= 1'b0;
		cfg_we         <= 1'b0;
		cfg_data       <= '0;
		cmd_ch.valid   <= 1'b0;
		cmd_ch.func    <= FN_PUSH;
		cmd_ch.value   <= '0;
		cfg_writes     = 0;
		send_idle_pct  = 18;
		recv_stall_pct = 85;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part, at reset capacity: empty pops on both stacks and the
		// spare function code first.
		send_command(FN_POP_ODD, 32'h0000_0000);
		send_command(FN_POP_EVEN, 32'hFFFF_FFFF);
		send_command(FN_SPARE, 32'hDEAD_BEEF);
		// Extremes of the value field; negative odd values belong on the odd stack.
		send_command(FN_PUSH, 32'h7FFF_FFFF);
		send_command(FN_PUSH, 32'hFFFF_FFFF);
		send_command(FN_PUSH, 32'h8000_0000);
		send_command(FN_PUSH, 32'h0000_0000);
		send_command(FN_PUSH, 32'h8000_0001);
		// Unwind both stacks; a popped -1 is ordinary data with status ok.
		send_command(FN_POP_ODD, '0);
		send_command(FN_POP_ODD, '0);
		send_command(FN_POP_EVEN, '0);
		send_command(FN_POP_EVEN, '0);
		send_command(FN_POP_EVEN, '0);
		send_command(FN_POP_ODD, '0);
		send_command(FN_POP_ODD, '0);

		// Two entries: fill from both ends, then overflow with either parity.
		wait_until_idle();
		write_capacity(9'd2);
		send_command(FN_PUSH, 32'h0000_0002);
		send_command(FN_PUSH, 32'h0000_0003);
		send_command(FN_PUSH, 32'h0000_0005);
		send_command(FN_PUSH, 32'h0000_0004);
		send_command(FN_POP_EVEN, '0);
		send_command(FN_PUSH, 32'h0000_0006);
		send_command(FN_SPARE, 32'h0000_0001);

		// A written zero acts as a single entry.
		wait_until_idle();
		write_capacity(9'd0);
		send_command(FN_PUSH, 32'h0000_0007);
		send_command(FN_PUSH, 32'h0000_0008);
		send_command(FN_POP_ODD, '0);

		// Random part: one capacity per segment, phases of idling rotate.
		for (int seg = 0; seg < SEGMENTS; seg++) begin
			wait_until_idle();
			if (seg == 4) begin
				send_idle_pct  = 85;
				recv_stall_pct = 18;
			end else if (seg == 8) begin
				send_idle_pct  = 0;
				recv_stall_pct = 0;
			end
			write_capacity(cap_plan[seg]);
			// Big stacks need a strong push bias to get anywhere near full.
			push_pct = (sb.cap >= 64) ? 85 : $urandom_range(75, 35);
			for (int i = 0; i < SEG_ITEMS; i++) begin
				// Let the block drain completely once mid-stream.
				if (seg == 5 && i == SEG_ITEMS / 2) begin
					wait_until_idle();
				end
				roll = $urandom_range(99);
				val  = $urandom;
				if (roll < push_pct) begin
					fn = FN_PUSH;
				end else if (roll < 97) begin
					fn = $urandom_range(1) ? FN_POP_ODD : FN_POP_EVEN;
				end else begin
					fn = FN_SPARE;
				end
				send_command(fn, val);
			end
		end

		// Collect the tail, then keep watching the pipe for stray responses.
		wait_until_idle();
		repeat (4) @(posedge clk);

		$display("Covered %0d stored pushes, %0d overflows, %0d pops with data, %0d empty pops",
			sb.n_stored, sb.n_overflow, sb.n_popped, sb.n_empty);
		$display("and %0d spare codes over %0d capacity writes; %0d responses checked",
			sb.n_spare, cfg_writes, sb.n_checked);
		if (sb.errors == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
